[design/prlt_pkg.sv]
// ----------------------------------------------------------------------------
// prlt_pkg: shared types, codes and character coding for the record table
// Holds request and status codes, the stored record layout, the
// controller/datapath command and status structs and the 6-bit and 5-bit
// character coding functions.
// ----------------------------------------------------------------------------
package prlt_pkg;

   // request kinds (req_tuser)
   localparam logic [1:0] REQ_INSERT   = 2'd0;
   localparam logic [1:0] REQ_DELETE   = 2'd1;
   localparam logic [1:0] REQ_READ_ALL = 2'd2;
   localparam logic [1:0] REQ_UNUSED   = 2'd3;

   // result status codes (rsp_tuser)
   localparam logic [2:0] STATUS_ADDED     = 3'd0;
   localparam logic [2:0] STATUS_DELETED   = 3'd1;
   localparam logic [2:0] STATUS_EMPTY     = 3'd2;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd3;
   localparam logic [2:0] STATUS_FULL      = 3'd4;
   localparam logic [2:0] STATUS_RECORD    = 3'd5;

   localparam logic [5:0] CODE6_OTHER = 6'd62;
   localparam logic [4:0] CODE5_OTHER = 5'd26;

   localparam int DATA_W   = 136;
   localparam int STATUS_W = 3;
   localparam int KIND_W   = 2;

   typedef struct packed {
      logic [39:0] numbers;     // category, location, available, borrowed, damaged from low up
      logic [14:0] tag_codes;   // first code at bits 14:10
      logic [47:0] name_codes;  // code i at bits 6i+5:6i
      logic [7:0]  key;
   } rec_type;

   typedef struct packed {
      logic       ptr_clr;
      logic       load_req;
      logic       rd_en;
      logic       ins_wr;
      logic       del_wr;
      logic       cnt_dec;
      logic       out_ld;
      logic       out_rec;
      logic       out_last;
      logic [2:0] out_status;
   } ctl_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_full;
      logic dat_match;
      logic dat_last;
      logic out_free;
   } ctl_sts_type;

   function automatic logic [5:0] enc6(input logic [7:0] c);
      logic [5:0] v;
      if (c >= 8'h41 && c <= 8'h5a) begin
         v = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         v = 6'(c - 8'h47);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = 6'(c + 8'h04);
      end else begin
         v = CODE6_OTHER;
      end
      return v;
   endfunction

   function automatic logic [7:0] dec6(input logic [5:0] v);
      logic [7:0] c;
      if (v <= 6'd25) begin
         c = 8'(v) + 8'h41;
      end else if (v <= 6'd51) begin
         c = 8'(v) + 8'h47;
      end else if (v <= 6'd61) begin
         c = 8'(v) - 8'h04;
      end else begin
         c = 8'h20;
      end
      return c;
   endfunction

   function automatic logic [4:0] enc5(input logic [7:0] c);
      logic [4:0] v;
      if (c >= 8'h41 && c <= 8'h5a) begin
         v = 5'(c - 8'h41);
      end else begin
         v = CODE5_OTHER;
      end
      return v;
   endfunction

   function automatic logic [7:0] dec5(input logic [4:0] v);
      logic [7:0] c;
      if (v <= 5'd25) begin
         c = 8'(v) + 8'h41;
      end else begin
         c = 8'h20;
      end
      return c;
   endfunction

endpackage

[design/prlt_ctrl.sv]
// ----------------------------------------------------------------------------
// prlt_ctrl: request sequencer for the record table
// Accepts one request at a time and steps the datapath through insert,
// delete scan with compaction, or read-all streaming.
// ----------------------------------------------------------------------------
module prlt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_kind,
   output prlt_pkg::ctl_cmd_type cmd,
   input  prlt_pkg::ctl_sts_type sts
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_INS      = 3'd1;
   localparam logic [2:0] S_DEL      = 3'd2;
   localparam logic [2:0] S_DEL_SCAN = 3'd3;
   localparam logic [2:0] S_RD       = 3'd4;
   localparam logic [2:0] S_RD_WAIT  = 3'd5;
   localparam logic [2:0] S_FIN      = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       found_ff, found_in;
   logic [2:0] fin_status_ff, fin_status_in;

   always_comb begin
      cmd           = '0;
      state_in      = state_ff;
      found_in      = found_ff;
      fin_status_in = fin_status_ff;
      req_tready    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               cmd.ptr_clr  = 1'b1;
               found_in     = 1'b0;
               unique case (req_kind)
                  prlt_pkg::REQ_INSERT:   state_in = S_INS;
                  prlt_pkg::REQ_DELETE:   state_in = S_DEL;
                  prlt_pkg::REQ_READ_ALL: state_in = S_RD;
                  prlt_pkg::REQ_UNUSED:   state_in = S_IDLE;
               endcase
            end
         end
         S_INS: begin
            if (sts.count_full) begin
               fin_status_in = prlt_pkg::STATUS_FULL;
            end else begin
               cmd.ins_wr    = 1'b1;
               fin_status_in = prlt_pkg::STATUS_ADDED;
            end
            state_in = S_FIN;
         end
         S_DEL: begin
            if (sts.count_zero) begin
               fin_status_in = prlt_pkg::STATUS_EMPTY;
               state_in      = S_FIN;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_DEL_SCAN;
            end
         end
         S_DEL_SCAN: begin
            // entries after the first match move down one place
            if (found_ff) begin
               cmd.del_wr = 1'b1;
            end else if (sts.dat_match) begin
               found_in = 1'b1;
            end
            if (sts.dat_last) begin
               if (found_ff || sts.dat_match) begin
                  cmd.cnt_dec   = 1'b1;
                  fin_status_in = prlt_pkg::STATUS_DELETED;
               end else begin
                  fin_status_in = prlt_pkg::STATUS_NOT_FOUND;
               end
               state_in = S_FIN;
            end else begin
               cmd.rd_en = 1'b1;
            end
         end
         S_RD: begin
            if (sts.count_zero) begin
               fin_status_in = prlt_pkg::STATUS_EMPTY;
               state_in      = S_FIN;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_RD_WAIT;
            end
         end
         S_RD_WAIT: begin
            if (sts.out_free) begin
               cmd.out_ld     = 1'b1;
               cmd.out_rec    = 1'b1;
               cmd.out_last   = sts.dat_last;
               cmd.out_status = prlt_pkg::STATUS_RECORD;
               if (sts.dat_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.rd_en = 1'b1;
               end
            end
         end
         S_FIN: begin
            if (sts.out_free) begin
               cmd.out_ld     = 1'b1;
               cmd.out_last   = 1'b1;
               cmd.out_status = fin_status_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         found_ff      <= 1'b0;
         fin_status_ff <= prlt_pkg::STATUS_ADDED;
      end else begin
         state_ff      <= state_in;
         found_ff      <= found_in;
         fin_status_ff <= fin_status_in;
      end
   end

endmodule

[design/prlt_datapath.sv]
// ----------------------------------------------------------------------------
// prlt_datapath: record storage, pointers and result register
// Encodes the request record, holds the entry memory with a registered
// read port, the fill count, the scan pointer and the output item.
// ----------------------------------------------------------------------------
module prlt_datapath #(
   parameter int CAPACITY = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [prlt_pkg::DATA_W-1:0]   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [prlt_pkg::DATA_W-1:0]   rsp_tdata,
   output logic [prlt_pkg::STATUS_W-1:0] rsp_tuser,
   output logic                          rsp_tlast,
   input  prlt_pkg::ctl_cmd_type          cmd,
   output prlt_pkg::ctl_sts_type          sts
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   prlt_pkg::rec_type mem [CAPACITY];

   prlt_pkg::rec_type req_rec_ff;
   prlt_pkg::rec_type enc_rec;
   prlt_pkg::rec_type rd_data_ff;
   prlt_pkg::rec_type wr_data;
   logic [IDX_W-1:0]  wr_addr;
   logic              wr_en;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [IDX_W-1:0]  dat_idx_ff;

   logic                          rsp_valid_ff;
   logic [prlt_pkg::DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [prlt_pkg::STATUS_W-1:0] rsp_user_ff;
   logic                          rsp_last_ff;
   logic                          out_free;

   // encode name and tag; bytes from the first zero byte on count as space
   always_comb begin
      logic       ended;
      logic [7:0] c;
      enc_rec.key     = req_tdata[7:0];
      enc_rec.numbers = req_tdata[135:96];
      ended = 1'b0;
      for (int i = 0; i < 8; i++) begin
         c = req_tdata[8 + 8*i +: 8];
         if (c == 8'h00) ended = 1'b1;
         enc_rec.name_codes[6*i +: 6] = ended ? prlt_pkg::CODE6_OTHER : prlt_pkg::enc6(c);
      end
      ended = 1'b0;
      for (int i = 0; i < 3; i++) begin
         c = req_tdata[72 + 8*i +: 8];
         if (c == 8'h00) ended = 1'b1;
         enc_rec.tag_codes[10 - 5*i +: 5] = ended ? prlt_pkg::CODE5_OTHER : prlt_pkg::enc5(c);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) req_rec_ff <= enc_rec;
   end

   always_comb begin
      wr_en   = cmd.ins_wr | cmd.del_wr;
      wr_addr = cmd.ins_wr ? count_ff[IDX_W-1:0] : dat_idx_ff - IDX_W'(1);
      wr_data = cmd.ins_wr ? req_rec_ff : rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (cmd.rd_en) begin
         rd_data_ff <= mem[ptr_ff[IDX_W-1:0]];
         dat_idx_ff <= ptr_ff[IDX_W-1:0];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.ins_wr) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
      ptr_in = ptr_ff;
      if (cmd.ptr_clr) begin
         ptr_in = '0;
      end else if (cmd.rd_en) begin
         ptr_in = ptr_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ptr_ff   <= '0;
      end else begin
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
      end
   end

   // result register: decode the read entry back to ascii
   always_comb begin
      rsp_data_in = '0;
      if (cmd.out_rec) begin
         rsp_data_in[7:0]     = rd_data_ff.key;
         rsp_data_in[135:96]  = rd_data_ff.numbers;
         for (int i = 0; i < 8; i++) begin
            rsp_data_in[8 + 8*i +: 8] = prlt_pkg::dec6(rd_data_ff.name_codes[6*i +: 6]);
         end
         for (int i = 0; i < 3; i++) begin
            rsp_data_in[72 + 8*i +: 8] = prlt_pkg::dec5(rd_data_ff.tag_codes[10 - 5*i +: 5]);
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_ld) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_ld) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= cmd.out_status;
         rsp_last_ff <= cmd.out_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      sts.count_zero = (count_ff == '0);
      sts.count_full = (count_ff >= CNT_W'(CAPACITY));
      sts.dat_match  = (rd_data_ff.key == req_rec_ff.key);
      sts.dat_last   = ((CNT_W'(dat_idx_ff) + CNT_W'(1)) == count_ff);
      sts.out_free   = out_free;
   end

endmodule

[design/packed_record_list_table.sv]
// ----------------------------------------------------------------------------
// packed_record_list_table: ordered record table with packed name and tag
// Keeps records in insertion order; insert, delete by key, read all.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one request; req_tuser is the kind (insert, delete,
//   read all) and req_tdata the key, name, tag and five numbers.
//   rsp channel returns status in rsp_tuser, the record in rsp_tdata and
//   rsp_tlast on the final item of each request.
//   One request is handled at a time; req_tready is high while idle.
//   Insert: the request is registered, then the entry is written at the
//   fill count unless the table is full. Delete: one pass over the stored
//   entries through the single read port of the entry memory, compaction
//   done in the same pass. Read all: one read per item, one item per
//   cycle while the receiver keeps rsp_tready high. The final result of
//   each request waits for a free output register; the next request is
//   taken the cycle after the final result is loaded.
//   A stalled receiver holds the output register; the sequencer waits and
//   the next request is taken once the last result sits in that register.
//   Reset empties the table (fill count zero) and drops any pending item;
//   the entry memory itself is not cleared.
// ----------------------------------------------------------------------------
module packed_record_list_table #(
   parameter int CAPACITY = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // key, name_text, tag_text, category, location, qty_available,
   // qty_borrowed, qty_damaged
   input  logic [prlt_pkg::DATA_W-1:0]   req_tdata,
   // req_type
   input  logic [prlt_pkg::KIND_W-1:0]   req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // rec_key, rec_name_text, rec_tag_text, rec_category, rec_location,
   // rec_qty_available, rec_qty_borrowed, rec_qty_damaged
   output logic [prlt_pkg::DATA_W-1:0]   rsp_tdata,
   // status
   output logic [prlt_pkg::STATUS_W-1:0] rsp_tuser,
   output logic                          rsp_tlast
);

   prlt_pkg::ctl_cmd_type cmd;
   prlt_pkg::ctl_sts_type sts;

   prlt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .cmd        (cmd),
      .sts        (sts)
   );

   prlt_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

[design/prlt_checker.sv]
// ----------------------------------------------------------------------------
// prlt_checker: port-level checks for the record table
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module prlt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic [prlt_pkg::KIND_W-1:0]   req_tuser,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [prlt_pkg::DATA_W-1:0]   rsp_tdata,
   input logic [prlt_pkg::STATUS_W-1:0] rsp_tuser,
   input logic                          rsp_tlast
);

   // a status item is always the only and final item of its request
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != prlt_pkg::STATUS_RECORD |-> rsp_tlast)
      else $error("status item without last");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != prlt_pkg::STATUS_RECORD |-> rsp_tdata == '0)
      else $error("status item carries record data");

   // a taken request blocks the next one while it is worked on
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser != prlt_pkg::REQ_UNUSED |=> !req_tready)
      else $error("request taken while another is in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
      && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result item changed");

endmodule

bind packed_record_list_table prlt_checker u_prlt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: stream-level testbench for the packed record list table
// Drives insert, delete and read-all requests into the req channel from a
// queue of pending items, predicts every reply with a local copy of the
// table (6-bit name and 5-bit tag coding included) and checks each rsp item
// field by field. Both sides idle at random; the receiver also holds off
// once for a long stretch so the table stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 64;
   localparam int IDLE_LIMIT  = 2000;
   localparam int DRAIN_WAIT  = 200;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AT     = 100;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  key;
      logic [63:0] name;
      logic [23:0] tag;
      logic [39:0] nums;       // category, location, available, borrowed, damaged
      logic        wait_idle;  // hold this item back until all replies are in
   } table_request_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  key;
      logic [63:0] name;
      logic [23:0] tag;
      logic [39:0] nums;
      logic        last;
   } table_reply_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [prlt_pkg::DATA_W-1:0]     req_tdata = '0;
   logic [prlt_pkg::KIND_W-1:0]     req_tuser = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [prlt_pkg::DATA_W-1:0]     rsp_tdata;
   logic [prlt_pkg::STATUS_W-1:0]   rsp_tuser;
   logic                            rsp_tlast;

   table_request_type pending_q[$];
   table_reply_type   reply_q[$];
   table_request_type offered;
   int             req_count = 0;
   int             error_count = 0;
   int             idle_cycles = 0;
   int             hold_left = 0;
   bit             hold_done = 1'b0;
   logic           steady;

   // local copy of the table
   logic [7:0]  tbl_key [TABLE_DEPTH];
   logic [47:0] tbl_name[TABLE_DEPTH];
   logic [14:0] tbl_tag [TABLE_DEPTH];
   logic [39:0] tbl_num [TABLE_DEPTH];
   int          tbl_count = 0;

   always #5 clock = ~clock;

   packed_record_list_table #(.CAPACITY(TABLE_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // no idling on either side in this window
   assign steady = (req_count >= 60) && (req_count < 95);

   function automatic logic [5:0] name_code_of(input logic [7:0] ch);
      if (ch >= 8'h41 && ch <= 8'h5a) return 6'(ch - 8'h41);
      if (ch >= 8'h61 && ch <= 8'h7a) return 6'(ch - 8'h61 + 8'd26);
      if (ch >= 8'h30 && ch <= 8'h39) return 6'(ch - 8'h30 + 8'd52);
      return prlt_pkg::CODE6_OTHER;
   endfunction

   function automatic logic [7:0] name_char_of(input logic [5:0] code);
      if (code <= 6'd25) return 8'h41 + 8'(code);
      if (code <= 6'd51) return 8'h61 + 8'(code) - 8'd26;
      if (code <= 6'd61) return 8'h30 + 8'(code) - 8'd52;
      return 8'h20;
   endfunction

   function automatic logic [4:0] tag_code_of(input logic [7:0] ch);
      if (ch >= 8'h41 && ch <= 8'h5a) return 5'(ch - 8'h41);
      return prlt_pkg::CODE5_OTHER;
   endfunction

   function automatic logic [7:0] tag_char_of(input logic [4:0] code);
      if (code <= 5'd25) return 8'h41 + 8'(code);
      return 8'h20;
   endfunction

   function automatic table_reply_type status_reply(input logic [2:0] status);
      table_reply_type rep;
      rep = '0;
      rep.status = status;
      rep.last = 1'b1;
      return rep;
   endfunction

   task automatic predict_replies(input table_request_type r);
      table_reply_type rep;
      logic [47:0]  nc;
      logic [14:0]  tc;
      logic [7:0]   ch;
      bit           ended;
      int           hit;
      case (r.kind)
         prlt_pkg::REQ_INSERT: begin
            if (tbl_count >= TABLE_DEPTH) begin
               reply_q.push_back(status_reply(prlt_pkg::STATUS_FULL));
            end else begin
               ended = 1'b0;
               for (int i = 0; i < 8; i++) begin
                  ch = r.name[8*i +: 8];
                  if (ch == 8'h00) ended = 1'b1;
                  nc[6*i +: 6] = ended ? prlt_pkg::CODE6_OTHER : name_code_of(ch);
               end
               ended = 1'b0;
               for (int i = 0; i < 3; i++) begin
                  ch = r.tag[8*i +: 8];
                  if (ch == 8'h00) ended = 1'b1;
                  // first tag character sits in the top code
                  tc[10-5*i +: 5] = ended ? prlt_pkg::CODE5_OTHER : tag_code_of(ch);
               end
               tbl_key[tbl_count]  = r.key;
               tbl_name[tbl_count] = nc;
               tbl_tag[tbl_count]  = tc;
               tbl_num[tbl_count]  = r.nums;
               tbl_count++;
               reply_q.push_back(status_reply(prlt_pkg::STATUS_ADDED));
            end
         end
         prlt_pkg::REQ_DELETE: begin
            if (tbl_count == 0) begin
               reply_q.push_back(status_reply(prlt_pkg::STATUS_EMPTY));
            end else begin
               hit = -1;
               for (int i = 0; i < tbl_count; i++) begin
                  if (hit < 0 && tbl_key[i] == r.key) hit = i;
               end
               if (hit < 0) begin
                  reply_q.push_back(status_reply(prlt_pkg::STATUS_NOT_FOUND));
               end else begin
                  for (int j = hit; j + 1 < tbl_count; j++) begin
                     tbl_key[j]  = tbl_key[j+1];
                     tbl_name[j] = tbl_name[j+1];
                     tbl_tag[j]  = tbl_tag[j+1];
                     tbl_num[j]  = tbl_num[j+1];
                  end
                  tbl_count--;
                  reply_q.push_back(status_reply(prlt_pkg::STATUS_DELETED));
               end
            end
         end
         prlt_pkg::REQ_READ_ALL: begin
            if (tbl_count == 0) begin
               reply_q.push_back(status_reply(prlt_pkg::STATUS_EMPTY));
            end else begin
               for (int i = 0; i < tbl_count; i++) begin
                  rep = '0;
                  rep.status = prlt_pkg::STATUS_RECORD;
                  rep.key = tbl_key[i];
                  for (int b = 0; b < 8; b++) begin
                     rep.name[8*b +: 8] = name_char_of(tbl_name[i][6*b +: 6]);
                  end
                  for (int b = 0; b < 3; b++) begin
                     rep.tag[8*b +: 8] = tag_char_of(tbl_tag[i][10-5*b +: 5]);
                  end
                  rep.nums = tbl_num[i];
                  rep.last = (i + 1 == tbl_count);
                  reply_q.push_back(rep);
               end
            end
         end
         default: begin
            // unused kind: no reply, table untouched
         end
      endcase
   endtask

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s expected %0h actual %0h", field, want, got);
         error_count++;
      end
   endtask

   // ---------------- stimulus helpers ----------------

   function automatic logic [63:0] random_name();
      logic [63:0] v;
      int          cls;
      for (int i = 0; i < 8; i++) begin
         cls = $urandom_range(0, 9);
         if (cls <= 2)      v[8*i +: 8] = 8'h41 + 8'($urandom_range(0, 25));
         else if (cls <= 4) v[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 25));
         else if (cls <= 6) v[8*i +: 8] = 8'h30 + 8'($urandom_range(0, 9));
         else if (cls == 7) v[8*i +: 8] = 8'h00;
         else               v[8*i +: 8] = 8'($urandom_range(0, 255));
      end
      return v;
   endfunction

   function automatic logic [23:0] random_tag();
      logic [23:0] v;
      int          cls;
      for (int i = 0; i < 3; i++) begin
         cls = $urandom_range(0, 9);
         if (cls <= 5)      v[8*i +: 8] = 8'h41 + 8'($urandom_range(0, 25));
         else if (cls == 6) v[8*i +: 8] = 8'h00;
         else               v[8*i +: 8] = 8'($urandom_range(0, 255));
      end
      return v;
   endfunction

   function automatic logic [7:0] pick_key();
      if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, 31));
   endfunction

   task automatic push_request(input logic [1:0] kind, input logic [7:0] key,
                               input logic [63:0] name, input logic [23:0] tag,
                               input logic [39:0] nums, input bit wait_idle);
      table_request_type r;
      r.kind = kind;
      r.key = key;
      r.name = name;
      r.tag = tag;
      r.nums = nums;
      r.wait_idle = wait_idle;
      pending_q.push_back(r);
   endtask

   task automatic push_random(input logic [1:0] kind, input bit wait_idle);
      push_request(kind, pick_key(), random_name(), random_tag(),
                   40'({$urandom(), $urandom()}), wait_idle);
   endtask

   task automatic push_mix(input int count, input int ins_pct, input int del_pct,
                           input int read_pct);
      int roll;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < ins_pct) begin
            push_random(prlt_pkg::REQ_INSERT, n == 0);
         end else if (roll < ins_pct + del_pct) begin
            push_random(prlt_pkg::REQ_DELETE, n == 0);
         end else if (roll < ins_pct + del_pct + read_pct) begin
            push_random(prlt_pkg::REQ_READ_ALL, n == 0);
         end else begin
            push_random(prlt_pkg::REQ_UNUSED, n == 0);
         end
      end
   endtask

   // ---------------- request side ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_replies(offered);
            req_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_q.size() != 0 && (steady || $urandom_range(0, 99) >= 11) &&
                (!pending_q[0].wait_idle || reply_q.size() == 0)) begin
               offered = pending_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= offered.kind;
               req_tdata  <= {offered.nums, offered.tag, offered.name, offered.key};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------- result side ----------------

   always @(posedge clock) begin : rsp_side
      table_reply_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (reply_q.size() == 0) begin
               $error("unexpected result item, status %0d", rsp_tuser);
               error_count++;
            end else begin
               want = reply_q.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_tuser));
               check_field("rec_key", 64'(want.key), 64'(rsp_tdata[7:0]));
               check_field("rec_name_text", want.name, rsp_tdata[71:8]);
               check_field("rec_tag_text", 64'(want.tag), 64'(rsp_tdata[95:72]));
               check_field("rec_category", 64'(want.nums[7:0]), 64'(rsp_tdata[103:96]));
               check_field("rec_location", 64'(want.nums[15:8]), 64'(rsp_tdata[111:104]));
               check_field("rec_qty_available", 64'(want.nums[23:16]),
                           64'(rsp_tdata[119:112]));
               check_field("rec_qty_borrowed", 64'(want.nums[31:24]),
                           64'(rsp_tdata[127:120]));
               check_field("rec_qty_damaged", 64'(want.nums[39:32]),
                           64'(rsp_tdata[135:128]));
               check_field("last", 64'(want.last), 64'(rsp_tlast));
            end
         end
         // one long hold-off so the table backs up into the request side
         if (!hold_done && req_count >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(0, 99) >= 11);
         end
      end
   end

   // ---------------- watchdog ----------------

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[packed_record_list_table] ERROR");
         $finish;
      end
   end

   // ---------------- sequence ----------------

   initial begin
      // directed: empty table, edges of the character coding, duplicates
      push_request(prlt_pkg::REQ_READ_ALL, 8'h00, '0, '0, '0, 1'b0);
      push_request(prlt_pkg::REQ_DELETE, 8'h00, '0, '0, '0, 1'b0);
      push_request(prlt_pkg::REQ_UNUSED, 8'hFF, '1, '1, '1, 1'b0);
      push_request(prlt_pkg::REQ_INSERT, 8'h00, 64'h5B40_3930_7A61_5A41, 24'h405A41,
                   '0, 1'b0);
      push_request(prlt_pkg::REQ_INSERT, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 24'hFFFFFF,
                   '1, 1'b0);
      // zero byte in the middle ends both strings
      push_request(prlt_pkg::REQ_INSERT, 8'h5A, 64'h6261_397A_5A00_6241, 24'h420041,
                   40'h01_02_03_04_05, 1'b0);
      push_request(prlt_pkg::REQ_INSERT, 8'h5A, 64'h0, 24'h0, 40'hA5_5A_A5_5A_A5, 1'b0);
      push_request(prlt_pkg::REQ_INSERT, 8'h11, 64'h017F_80FF_3A2F_7B60, 24'h605B61,
                   40'h80_7F_01_FE_10, 1'b0);
      push_request(prlt_pkg::REQ_READ_ALL, 8'h00, '0, '0, '0, 1'b0);
      // duplicate key: the oldest one goes
      push_request(prlt_pkg::REQ_DELETE, 8'h5A, '0, '0, '0, 1'b0);
      push_request(prlt_pkg::REQ_READ_ALL, 8'h00, '0, '0, '0, 1'b0);
      push_request(prlt_pkg::REQ_DELETE, 8'h77, '0, '0, '0, 1'b0);
      push_request(prlt_pkg::REQ_DELETE, 8'h00, '0, '0, '0, 1'b0);
      push_request(prlt_pkg::REQ_DELETE, 8'h11, '0, '0, '0, 1'b0);
      push_request(prlt_pkg::REQ_READ_ALL, 8'h00, '0, '0, '0, 1'b0);
      push_request(prlt_pkg::REQ_UNUSED, 8'h00, '0, '0, '0, 1'b0);
      push_request(prlt_pkg::REQ_DELETE, 8'hFF, '0, '0, '0, 1'b0);
      push_request(prlt_pkg::REQ_DELETE, 8'h5A, '0, '0, '0, 1'b0);
      push_request(prlt_pkg::REQ_READ_ALL, 8'h00, '0, '0, '0, 1'b0);
      push_request(prlt_pkg::REQ_DELETE, 8'h5A, '0, '0, '0, 1'b0);

      // random mix on a small table
      push_mix(30, 55, 25, 13);

      // fill to capacity, then push past it
      for (int n = 0; n < TABLE_DEPTH; n++) push_random(prlt_pkg::REQ_INSERT, n == 0);
      push_random(prlt_pkg::REQ_INSERT, 1'b0);
      push_random(prlt_pkg::REQ_READ_ALL, 1'b0);
      push_random(prlt_pkg::REQ_DELETE, 1'b0);
      push_random(prlt_pkg::REQ_INSERT, 1'b0);
      push_random(prlt_pkg::REQ_INSERT, 1'b0);
      push_random(prlt_pkg::REQ_READ_ALL, 1'b0);

      // drain with deletes mixed in
      push_mix(35, 25, 50, 17);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || req_tvalid) @(posedge clock);
      while (reply_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (reply_q.size() != 0) begin
         $error("%0d result items never arrived", reply_q.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("[packed_record_list_table] OK");
      end else begin
         $display("[packed_record_list_table] ERROR");
      end
      $finish;
   end

endmodule
